>>> design/arr_pkg.sv
// Shared constants and register map for the annulus radial remap address generator.
package arr_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int RADIUS_BITS = 10;
  localparam int CENTER_BITS = 11;
  localparam int DIM_BITS    = 12;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  localparam logic [RADIUS_BITS-1:0] DST_OUTER_RST = 10'd200;
  localparam logic [RADIUS_BITS-1:0] DST_INNER_RST = 10'd0;
  localparam logic [RADIUS_BITS-1:0] SRC_OUTER_RST = 10'd100;
  localparam logic [RADIUS_BITS-1:0] SRC_INNER_RST = 10'd0;
  localparam logic [CENTER_BITS-1:0] CENTER_COL_RST = 11'd200;
  localparam logic [CENTER_BITS-1:0] CENTER_ROW_RST = 11'd200;
  localparam logic [DIM_BITS-1:0]    IMAGE_WIDTH_RST  = 12'd512;
  localparam logic [DIM_BITS-1:0]    IMAGE_HEIGHT_RST = 12'd512;

  typedef enum logic [2:0] {
    REG_DST_OUTER  = 3'd0,
    REG_DST_INNER  = 3'd1,
    REG_SRC_OUTER  = 3'd2,
    REG_SRC_INNER  = 3'd3,
    REG_CENTER_COL = 3'd4,
    REG_CENTER_ROW = 3'd5,
    REG_IMG_WIDTH  = 3'd6,
    REG_IMG_HEIGHT = 3'd7
  } reg_idx_t;

endpackage

>>> design/annulus_radial_remap_address.sv
// Annulus radial remap address generator: pipelined ring-to-ring coordinate mapping.
//
// Usage: destination pixel coordinates enter on the s_axis channel (out_row, out_col),
// one transfer per clock. For each one the block emits one transfer on m_axis: the
// source row and column to copy and, in tuser, a pixel-valid flag (coordinates are
// zero when the flag is low). Ring radii, ring centre and source image size are set
// through the APB port; write them only while the pipeline is empty.
// Pipeline: the square root and the radius scaling divide each resolve one bit per
// stage over 10+FRAC_BITS stages, and the two lateral divides one bit per stage
// over 11 stages; these chains set the depth.
// Throughput: one item per clock, sustained while m_axis takes each transfer.
// Stall: the whole pipeline advances together; while m_axis holds a transfer that
// is not taken, every stage holds and s_axis_tready drops, so nothing is lost or
// repeated. The output register keeps its transfer until it is taken.
// Reset (synchronous, active high): all stage valid bits clear, the registers take
// their default values; the pipeline is empty and ready the next cycle.
module annulus_radial_remap_address #(
  parameter int COORD_BITS = arr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = arr_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // APB register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [arr_pkg::APB_AW-1:0] paddr,
  input  logic [arr_pkg::APB_DW-1:0] pwdata,
  output logic [arr_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // destination coordinates
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // out_row, out_col
  // source address
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata, // src_row, src_col
  output logic m_axis_tuser                                // pixel_valid
);
  import arr_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int RB   = RADIUS_BITS;
  localparam int BW   = ((2*CB+7)/8)*8;
  localparam int DW   = ((CB > RB) ? CB : RB) + 1;  // signed dx, dy
  localparam int SQW  = 2*DW;
  localparam int QB   = RB + FB;                    // root and radius-scale bits
  localparam int RADB = 2*QB;
  localparam int REMW = QB + 2;
  localparam int NW   = QB + RB;
  localparam int QQ   = RB + 1;                     // lateral quotient bits
  localparam int PW   = QB + DW;
  localparam int LW   = QQ + 1;                     // signed lateral offset
  localparam int IW   = ((DIM_BITS > LW) ? DIM_BITS : LW) + 2;

  // ---------------- configuration registers ----------------
  logic [RB-1:0] dst_outer, dst_inner, src_outer, src_inner;
  logic [CENTER_BITS-1:0] center_col, center_row;
  logic [DIM_BITS-1:0] image_width, image_height;
  logic [2*RB-1:0] rsq, rsq_outer, msq, msq_outer;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_outer    <= DST_OUTER_RST;
      dst_inner    <= DST_INNER_RST;
      src_outer    <= SRC_OUTER_RST;
      src_inner    <= SRC_INNER_RST;
      center_col   <= CENTER_COL_RST;
      center_row   <= CENTER_ROW_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DST_OUTER:  dst_outer    <= pwdata[RB-1:0];
        REG_DST_INNER:  dst_inner    <= pwdata[RB-1:0];
        REG_SRC_OUTER:  src_outer    <= pwdata[RB-1:0];
        REG_SRC_INNER:  src_inner    <= pwdata[RB-1:0];
        REG_CENTER_COL: center_col   <= pwdata[CENTER_BITS-1:0];
        REG_CENTER_ROW: center_row   <= pwdata[CENTER_BITS-1:0];
        REG_IMG_WIDTH:  image_width  <= pwdata[DIM_BITS-1:0];
        REG_IMG_HEIGHT: image_height <= pwdata[DIM_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DST_OUTER:  prdata = APB_DW'(dst_outer);
      REG_DST_INNER:  prdata = APB_DW'(dst_inner);
      REG_SRC_OUTER:  prdata = APB_DW'(src_outer);
      REG_SRC_INNER:  prdata = APB_DW'(src_inner);
      REG_CENTER_COL: prdata = APB_DW'(center_col);
      REG_CENTER_ROW: prdata = APB_DW'(center_row);
      REG_IMG_WIDTH:  prdata = APB_DW'(image_width);
      REG_IMG_HEIGHT: prdata = APB_DW'(image_height);
    endcase
  end

  // Squared radii, refreshed every cycle; the user must change registers only while idle; the block does not check.
  always_ff @(posedge clk) begin
    rsq       <= dst_inner * dst_inner;
    rsq_outer <= dst_outer * dst_outer;
    msq       <= src_inner * src_inner;
    msq_outer <= src_outer * src_outer;
  end

  logic [RB-1:0] rdiff, mdiff;
  assign rdiff = dst_outer - dst_inner;
  assign mdiff = src_outer - src_inner;

  // ---------------- global advance ----------------
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage A: offsets from ring centre ----------------
  logic va;
  logic signed [DW-1:0] dxa, dya;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dya <= $signed(DW'(s_axis_tdata[CB-1:0]))    - $signed(DW'(dst_outer));
      dxa <= $signed(DW'(s_axis_tdata[2*CB-1:CB])) - $signed(DW'(dst_outer));
    end
  end

  // ---------------- stage B: squares ----------------
  logic vb;
  logic signed [DW-1:0] dxb, dyb;
  logic signed [SQW-1:0] sqxb, sqyb;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dxb  <= dxa;
      dyb  <= dya;
      sqxb <= dxa * dxa;
      sqyb <= dya * dya;
    end
  end

  // ---------------- stage C: destination annulus test ----------------
  logic vc, okc;
  logic signed [DW-1:0] dxc, dyc;
  logic [2*RB-1:0] d2c;
  logic [SQW:0] d2b;
  assign d2b = (SQW+1)'($unsigned(sqxb)) + (SQW+1)'($unsigned(sqyb));
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dxc <= dxb;
      dyc <= dyb;
      d2c <= d2b[2*RB-1:0];
      okc <= (dst_inner < dst_outer) && (d2b < (SQW+1)'(rsq_outer)) &&
             (d2b >= (SQW+1)'(rsq));
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic            sq_v    [QB];
  logic            sq_ok   [QB];
  logic [REMW-1:0] sq_rem  [QB];
  logic [QB-1:0]   sq_root [QB];
  logic [RADB-1:0] sq_rad  [QB];
  logic signed [DW-1:0] sq_dx [QB];
  logic signed [DW-1:0] sq_dy [QB];

  for (genvar k = 0; k < QB; k++) begin : g_sqrt
    logic iv, iok;
    logic [REMW-1:0] irem, remsh, trial;
    logic [QB-1:0] iroot;
    logic [RADB-1:0] irad;
    logic signed [DW-1:0] idx, idy;
    if (k == 0) begin : g_first
      assign iv    = vc;
      assign iok   = okc;
      assign irem  = '0;
      assign iroot = '0;
      assign irad  = {d2c, {(2*FB){1'b0}}};
      assign idx   = dxc;
      assign idy   = dyc;
    end else begin : g_next
      assign iv    = sq_v[k-1];
      assign iok   = sq_ok[k-1];
      assign irem  = sq_rem[k-1];
      assign iroot = sq_root[k-1];
      assign irad  = sq_rad[k-1];
      assign idx   = sq_dx[k-1];
      assign idy   = sq_dy[k-1];
    end
    assign remsh = {irem[REMW-3:0], irad[RADB-1 -: 2]};
    assign trial = {iroot, 2'b01};
    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else if (en) sq_v[k] <= iv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ok[k]  <= iok;
        sq_rad[k] <= irad << 2;
        sq_dx[k]  <= idx;
        sq_dy[k]  <= idy;
        if (remsh >= trial) begin
          sq_rem[k]  <= remsh - trial;
          sq_root[k] <= {iroot[QB-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= remsh;
          sq_root[k] <= {iroot[QB-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage E: radius numerator ----------------
  logic ve, oke, dze;
  logic [QB-1:0] de;
  logic [NW-1:0] nume;
  logic signed [DW-1:0] dxe, dye;
  logic [QB-1:0] dsub;
  assign dsub = sq_root[QB-1] - {dst_inner, {FB{1'b0}}};
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= sq_v[QB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      oke  <= sq_ok[QB-1] && (src_inner < src_outer);
      dze  <= (sq_root[QB-1] == '0);
      de   <= sq_root[QB-1];
      nume <= NW'(dsub) * NW'(mdiff);
      dxe  <= sq_dx[QB-1];
      dye  <= sq_dy[QB-1];
    end
  end

  // ---------------- divide by ring width, one quotient bit per stage ----------------
  logic            dv_v   [QB];
  logic            dv_ok  [QB];
  logic            dv_dz  [QB];
  logic [QB-1:0]   dv_d   [QB];
  logic [NW-1:0]   dv_rem [QB];
  logic [QB-1:0]   dv_q   [QB];
  logic signed [DW-1:0] dv_dx [QB];
  logic signed [DW-1:0] dv_dy [QB];

  for (genvar k = 0; k < QB; k++) begin : g_rdiv
    localparam int BIT = QB - 1 - k;
    logic iv, iok, idz;
    logic [QB-1:0] id, iq;
    logic [NW-1:0] irem, sub;
    logic signed [DW-1:0] idx, idy;
    if (k == 0) begin : g_first
      assign iv   = ve;
      assign iok  = oke;
      assign idz  = dze;
      assign id   = de;
      assign irem = nume;
      assign iq   = '0;
      assign idx  = dxe;
      assign idy  = dye;
    end else begin : g_next
      assign iv   = dv_v[k-1];
      assign iok  = dv_ok[k-1];
      assign idz  = dv_dz[k-1];
      assign id   = dv_d[k-1];
      assign irem = dv_rem[k-1];
      assign iq   = dv_q[k-1];
      assign idx  = dv_dx[k-1];
      assign idy  = dv_dy[k-1];
    end
    assign sub = NW'(rdiff) << BIT;
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (en) dv_v[k] <= iv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ok[k] <= iok;
        dv_dz[k] <= idz;
        dv_d[k]  <= id;
        dv_dx[k] <= idx;
        dv_dy[k] <= idy;
        if (irem >= sub) begin
          dv_rem[k]   <= irem - sub;
          dv_q[k]     <= iq | (QB'(1) << BIT);
        end else begin
          dv_rem[k]   <= irem;
          dv_q[k]     <= iq;
        end
      end
    end
  end

  // ---------------- stage F: source radius, centre-pixel substitution ----------------
  // At the centre the angle is zero: divide s by 2^FB along +x.
  logic vf, okf;
  logic [QB-1:0] sf, dvf;
  logic signed [DW-1:0] dxf, dyf;
  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= dv_v[QB-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      okf <= dv_ok[QB-1];
      sf  <= {src_inner, {FB{1'b0}}} + dv_q[QB-1];
      if (dv_dz[QB-1]) begin
        dvf <= QB'(1) << FB;
        dxf <= DW'(1);
        dyf <= '0;
      end else begin
        dvf <= dv_d[QB-1];
        dxf <= dv_dx[QB-1];
        dyf <= dv_dy[QB-1];
      end
    end
  end

  // ---------------- stage G: lateral numerators, sign-magnitude ----------------
  logic vg, okg, nxg, nyg;
  logic [QB-1:0] dvg;
  logic [PW-1:0] pxg, pyg;
  logic [DW-1:0] axf, ayf;
  assign axf = (dxf < 0) ? $unsigned(-dxf) : $unsigned(dxf);
  assign ayf = (dyf < 0) ? $unsigned(-dyf) : $unsigned(dyf);
  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else if (en) vg <= vf;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      okg <= okf;
      dvg <= dvf;
      nxg <= (dxf < 0);
      nyg <= (dyf < 0);
      pxg <= PW'(sf) * PW'(axf);
      pyg <= PW'(sf) * PW'(ayf);
    end
  end

  // ---------------- lateral divides, two lanes, one bit per stage ----------------
  logic          lt_v   [QQ];
  logic          lt_ok  [QQ];
  logic          lt_nx  [QQ];
  logic          lt_ny  [QQ];
  logic [QB-1:0] lt_d   [QQ];
  logic [PW-1:0] lt_rx  [QQ];
  logic [PW-1:0] lt_ry  [QQ];
  logic [QQ-1:0] lt_qx  [QQ];
  logic [QQ-1:0] lt_qy  [QQ];

  for (genvar k = 0; k < QQ; k++) begin : g_ldiv
    localparam int BIT = QQ - 1 - k;
    logic iv, iok, inx, iny;
    logic [QB-1:0] id;
    logic [PW-1:0] irx, iry, sub;
    logic [QQ-1:0] iqx, iqy;
    if (k == 0) begin : g_first
      assign iv  = vg;
      assign iok = okg;
      assign inx = nxg;
      assign iny = nyg;
      assign id  = dvg;
      assign irx = pxg;
      assign iry = pyg;
      assign iqx = '0;
      assign iqy = '0;
    end else begin : g_next
      assign iv  = lt_v[k-1];
      assign iok = lt_ok[k-1];
      assign inx = lt_nx[k-1];
      assign iny = lt_ny[k-1];
      assign id  = lt_d[k-1];
      assign irx = lt_rx[k-1];
      assign iry = lt_ry[k-1];
      assign iqx = lt_qx[k-1];
      assign iqy = lt_qy[k-1];
    end
    assign sub = PW'(id) << BIT;
    always_ff @(posedge clk) begin
      if (rst) lt_v[k] <= 1'b0;
      else if (en) lt_v[k] <= iv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lt_ok[k] <= iok;
        lt_nx[k] <= inx;
        lt_ny[k] <= iny;
        lt_d[k]  <= id;
        if (irx >= sub) begin
          lt_rx[k] <= irx - sub;
          lt_qx[k] <= iqx | (QQ'(1) << BIT);
        end else begin
          lt_rx[k] <= irx;
          lt_qx[k] <= iqx;
        end
        if (iry >= sub) begin
          lt_ry[k] <= iry - sub;
          lt_qy[k] <= iqy | (QQ'(1) << BIT);
        end else begin
          lt_ry[k] <= iry;
          lt_qy[k] <= iqy;
        end
      end
    end
  end

  // ---------------- stage H: floor with sign ----------------
  // Negative numerator: floor is minus the ceiling of the magnitude quotient.
  logic vh, okh;
  logic signed [LW-1:0] lxh, lyh;
  logic [LW-1:0] magx, magy;
  assign magx = LW'(lt_qx[QQ-1]) + LW'(lt_nx[QQ-1] && (lt_rx[QQ-1] != '0));
  assign magy = LW'(lt_qy[QQ-1]) + LW'(lt_ny[QQ-1] && (lt_ry[QQ-1] != '0));
  always_ff @(posedge clk) begin
    if (rst) vh <= 1'b0;
    else if (en) vh <= lt_v[QQ-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      okh <= lt_ok[QQ-1];
      lxh <= lt_nx[QQ-1] ? -$signed(magx) : $signed(magx);
      lyh <= lt_ny[QQ-1] ? -$signed(magy) : $signed(magy);
    end
  end

  // ---------------- stage I: local squares and box test ----------------
  logic vi, oki;
  logic signed [LW-1:0] lxi, lyi, mext;
  logic signed [2*LW-1:0] sqxi, sqyi;
  assign mext = $signed(LW'(src_outer));
  always_ff @(posedge clk) begin
    if (rst) vi <= 1'b0;
    else if (en) vi <= vh;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      oki  <= okh && (lxh >= -mext) && (lxh < mext) && (lyh >= -mext) && (lyh < mext);
      lxi  <= lxh;
      lyi  <= lyh;
      sqxi <= lxh * lxh;
      sqyi <= lyh * lyh;
    end
  end

  // ---------------- stage J: source annulus, image bounds, output register ----------------
  logic [2*LW:0] l2i;
  logic signed [IW-1:0] irow, icol;
  logic pix_ok;
  assign l2i  = (2*LW+1)'($unsigned(sqxi)) + (2*LW+1)'($unsigned(sqyi));
  assign irow = $signed(IW'(center_row)) + IW'(lyi);
  assign icol = $signed(IW'(center_col)) + IW'(lxi);
  assign pix_ok = oki &&
                  (l2i < (2*LW+1)'(msq_outer)) && (l2i >= (2*LW+1)'(msq)) &&
                  (irow >= 0) && (icol >= 0) &&
                  (irow < $signed(IW'(image_height))) &&
                  (icol < $signed(IW'(image_width))) &&
                  (($unsigned(irow) >> CB) == '0) && (($unsigned(icol) >> CB) == '0);

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vi;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= pix_ok;
      // Drop coordinates of pixels drawn as zero colour.
      m_axis_tdata <= pix_ok ? BW'({CB'($unsigned(icol)), CB'($unsigned(irow))}) : '0;
    end
  end

`ifndef SYNTH
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid pixel carries a nonzero address");
  a_row_in_image: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> BW'(m_axis_tdata[CB-1:0]) < BW'(image_height))
    else $error("source row outside image");
  a_root_in_ring: assert property (@(posedge clk) disable iff (rst)
    sq_v[QB-1] && sq_ok[QB-1] |-> sq_root[QB-1] < {dst_outer, {FB{1'b0}}})
    else $error("root beyond outer radius");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !vc && !sq_v[QB-1])
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> dv/annulus_radial_remap_address_checker.sv
// Checker for the annulus remap: snoops APB writes, predicts source addresses, compares.
`timescale 1ns / 100ps
module annulus_radial_remap_address_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [arr_pkg::APB_AW-1:0]    paddr,
  input  logic [arr_pkg::APB_DW-1:0]    pwdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [23:0]                   m_axis_tdata,
  input  logic                          m_axis_tuser,
  output int                            errors,
  output int                            pending,
  output int                            n_valid
);
  import arr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [CB-1:0] row;
    logic [CB-1:0] col;
    logic          valid;
  } src_addr_t;

  src_addr_t addr_q[$];

  logic [RADIUS_BITS-1:0] dst_outer, dst_inner, src_outer, src_inner;
  logic [CENTER_BITS-1:0] ctr_col, ctr_row;
  logic [DIM_BITS-1:0]    img_w, img_h;

  // floor(sqrt(v) * 2^FB), one result bit per digit pair
  function automatic longint root_q(longint v);
    longint root, rem, trial, pair;
    int     pos;
    root = 0;
    rem  = 0;
    for (int k = 0; k < 17 + FB; k++) begin
      pos  = 16 - k;
      pair = (pos >= 0) ? ((v >> (2 * pos)) & 3) : 0;
      rem  = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint div_floor(longint n, longint dv);
    longint q;
    q = n / dv;
    if ((n % dv) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic src_addr_t remap(logic [CB-1:0] orow, logic [CB-1:0] ocol);
    src_addr_t res;
    longint big_r, small_r, big_m, small_m, dy, dx, d2, d, s, lx, ly, lrow, lcol, l2;
    longint irow, icol;
    res = '0;
    big_r = dst_outer;
    small_r = dst_inner;
    big_m = src_outer;
    small_m = src_inner;
    dy = longint'(orow) - big_r;
    dx = longint'(ocol) - big_r;
    d2 = dx * dx + dy * dy;
    if (small_r >= big_r || d2 >= big_r * big_r || d2 < small_r * small_r) return res;
    d = root_q(d2);
    s = (small_m << FB) + ((d - (small_r << FB)) * (big_m - small_m)) / (big_r - small_r);
    // centre pixel: angle taken as zero
    if (d == 0) begin
      lx = div_floor(s, longint'(1) << FB);
      ly = 0;
    end else begin
      lx = div_floor(s * dx, d);
      ly = div_floor(s * dy, d);
    end
    lrow = big_m + ly;
    lcol = big_m + lx;
    l2 = lx * lx + ly * ly;
    if (lrow < 0 || lcol < 0 || lrow >= 2 * big_m || lcol >= 2 * big_m ||
        l2 >= big_m * big_m || l2 < small_m * small_m) return res;
    irow = longint'(ctr_row) - big_m + lrow;
    icol = longint'(ctr_col) - big_m + lcol;
    if (irow < 0 || icol < 0 || irow >= longint'(img_h) || icol >= longint'(img_w) ||
        irow >= (longint'(1) << CB) || icol >= (longint'(1) << CB)) return res;
    res.row   = irow[CB-1:0];
    res.col   = icol[CB-1:0];
    res.valid = 1'b1;
    return res;
  endfunction

  assign pending = addr_q.size();

  always @(posedge clk) begin
    src_addr_t exp_a;
    if (rst) begin
      dst_outer <= DST_OUTER_RST;
      dst_inner <= DST_INNER_RST;
      src_outer <= SRC_OUTER_RST;
      src_inner <= SRC_INNER_RST;
      ctr_col   <= CENTER_COL_RST;
      ctr_row   <= CENTER_ROW_RST;
      img_w     <= IMAGE_WIDTH_RST;
      img_h     <= IMAGE_HEIGHT_RST;
      addr_q.delete();
      errors  <= 0;
      n_valid <= 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_DST_OUTER:  dst_outer <= pwdata[RADIUS_BITS-1:0];
          REG_DST_INNER:  dst_inner <= pwdata[RADIUS_BITS-1:0];
          REG_SRC_OUTER:  src_outer <= pwdata[RADIUS_BITS-1:0];
          REG_SRC_INNER:  src_inner <= pwdata[RADIUS_BITS-1:0];
          REG_CENTER_COL: ctr_col   <= pwdata[CENTER_BITS-1:0];
          REG_CENTER_ROW: ctr_row   <= pwdata[CENTER_BITS-1:0];
          REG_IMG_WIDTH:  img_w     <= pwdata[DIM_BITS-1:0];
          REG_IMG_HEIGHT: img_h     <= pwdata[DIM_BITS-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        addr_q.push_back(remap(s_axis_tdata[CB-1:0], s_axis_tdata[2*CB-1:CB]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser) n_valid <= n_valid + 1;
        if (addr_q.size() == 0) begin
          if (errors < 10) $display("unexpected output transfer %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_a = addr_q.pop_front();
          if (m_axis_tdata[CB-1:0] !== exp_a.row || m_axis_tdata[2*CB-1:CB] !== exp_a.col ||
              m_axis_tdata[23:2*CB] !== '0 || m_axis_tuser !== exp_a.valid) begin
            if (errors < 10)
              $display("mismatch: exp row %0d col %0d valid %0d, got row %0d col %0d valid %0b",
                       exp_a.row, exp_a.col, exp_a.valid, m_axis_tdata[CB-1:0],
                       m_axis_tdata[2*CB-1:CB], m_axis_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/annulus_radial_remap_address_tb.sv
// Testbench top for the annulus remap: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module annulus_radial_remap_address_tb;
  import arr_pkg::*;

  localparam int LATENCY  = 2 * (10 + FRAC_BITS_DEF) + 20;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tuser;

  int errors, pending, n_valid;
  int sent = 0;
  int idle_cycles = 0;
  int n_phases = 0;
  logic rx_calm = 1'b0;     // receiver starts no random stalls while set
  logic tx_calm = 1'b0;     // sender inserts no random gaps while set
  logic hold_go = 1'b0;     // one long receiver hold-off
  logic hold_done = 1'b0;
  int rx_gap = 0;
  int hold_cnt = 0;
  logic [9:0] cur_outer = 10'd200;

  always #4 clk = ~clk;

  annulus_radial_remap_address uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser)
  );

  annulus_radial_remap_address_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .errors(errors), .pending(pending), .n_valid(n_valid)
  );

  // Receiver: random stalls, mostly short, a few long, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 5) == 0)
        rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog expired with %0d transfers outstanding", pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline, then load a full register setting.
  task automatic load_ring(int ro, int ri, int so, int si, int cc, int cr, int iw, int ih);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    apb_write(REG_DST_OUTER, ro);
    apb_write(REG_DST_INNER, ri);
    apb_write(REG_SRC_OUTER, so);
    apb_write(REG_SRC_INNER, si);
    apb_write(REG_CENTER_COL, cc);
    apb_write(REG_CENTER_ROW, cr);
    apb_write(REG_IMG_WIDTH, iw);
    apb_write(REG_IMG_HEIGHT, ih);
    cur_outer = ro[9:0];
    n_phases++;
  endtask

  // Offer one pixel; hold until the transfer is taken.
  task automatic push_pixel(int row, int col);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, col[10:0], row[10:0]};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic random_pixels(int count);
    int span, row, col;
    for (int i = 0; i < count; i++) begin
      span = 2 * cur_outer;
      if (span > 2048) span = 2048;
      if ($urandom_range(0, 9) < 8) begin
        row = $urandom_range(0, span - 1);
        col = $urandom_range(0, span - 1);
      end else begin
        row = $urandom_range(0, 2047);
        col = $urandom_range(0, 2047);
      end
      if (i % 150 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      push_pixel(row, col);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: corners, centre pixel, ring edges, field extremes.
    push_pixel(0, 0);
    push_pixel(2047, 2047);
    push_pixel(200, 200);
    push_pixel(200, 201);
    push_pixel(201, 200);
    push_pixel(0, 200);
    push_pixel(200, 0);
    push_pixel(399, 200);
    push_pixel(200, 399);
    push_pixel(1, 200);
    push_pixel(59, 59);
    push_pixel(341, 341);
    push_pixel(1365, 682);
    push_pixel(682, 1365);
    random_pixels(250);

    // Annulus on both sides, centre near the image corner so coordinates go negative.
    load_ring(120, 40, 90, 30, 20, 2000, 300, 2048);
    push_pixel(120, 120);
    push_pixel(120, 160);
    push_pixel(120, 159);
    random_pixels(100);
    // pause until everything has come back
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    random_pixels(150);
    // long hold-off while offering continuously
    tx_calm = 1'b1;
    hold_go <= 1'b1;
    for (int i = 0; i < 200; i++) push_pixel($urandom_range(0, 239), $urandom_range(0, 239));
    random_pixels(50);

    // Largest radii, centre at the top of the range, largest image.
    load_ring(1023, 0, 1023, 0, 2047, 2047, 2048, 2048);
    push_pixel(1023, 1023);
    push_pixel(0, 1023);
    push_pixel(2045, 2045);
    random_pixels(300);

    // Smallest rings, centre at zero.
    load_ring(1, 0, 1, 0, 0, 0, 1, 1);
    push_pixel(0, 0);
    push_pixel(1, 1);
    random_pixels(60);

    // Destination inner not below outer: nothing valid.
    load_ring(300, 300, 200, 10, 500, 500, 1024, 1024);
    random_pixels(80);

    // Source inner not below outer: nothing valid.
    load_ring(300, 100, 50, 900, 500, 500, 1024, 1024);
    random_pixels(80);

    // Wide annulus with a scale-up, mixed centre.
    load_ring(500, 250, 1000, 999, 1024, 700, 2048, 1500);
    random_pixels(300);

    // Back toward defaults with a thin ring.
    load_ring(200, 199, 100, 0, 200, 200, 512, 512);
    random_pixels(150);

    s_tvalid <= 1'b0;
    rx_calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("pixels sent: %0d across %0d register settings plus reset defaults", sent, n_phases);
    $display("valid source addresses seen: %0d", n_valid);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
